// File: design/mbps_pkg.sv
// shared types and constants for the motor bus poll sequencer
package mbps_pkg;

   localparam int MOTOR_COUNT = 4;
   localparam int MOTOR_IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
   localparam logic [3:0] MOTOR_LIMIT = 4'(MOTOR_COUNT);

   localparam logic [7:0] ADDRESS_BASE_RESET = 8'd82;
   localparam logic [7:0] ST_DATA_NACK = 8'h30;
   localparam logic [7:0] ST_READ_ACK = 8'h40;
   localparam logic [2:0] WRITER_END = 3'd4;
   localparam logic [7:0] COUNT_MAX = 8'd255;
   localparam logic [1:0] LAST_READ_SLOT = 2'd3;

   localparam logic OP_BUS_DONE = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   typedef enum logic [2:0] {
      ACT_START   = 3'd0,
      ACT_SEND    = 3'd1,
      ACT_STOP    = 3'd2,
      ACT_RESTART = 3'd3,
      ACT_RX_ACK  = 3'd4,
      ACT_RX_NACK = 3'd5
   } bus_action_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_COMMAND   = 3'd1,
      PH_DATA_DONE = 3'd2,
      PH_READ_ADDR = 3'd3,
      PH_RX_FIRST  = 3'd4,
      PH_RX_SECOND = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      RPT_NONE      = 2'd0,
      RPT_READ_DONE = 2'd1,
      RPT_ABSENT    = 2'd2,
      RPT_PRESENT   = 2'd3
   } report_type;

   typedef struct packed {
      logic       op;
      logic [7:0] bus_status;
      logic [7:0] rx_byte;
      logic [7:0] command_0;
      logic [7:0] command_1;
      logic [7:0] command_2;
      logic [7:0] command_3;
   } req_item_type;

   typedef struct packed {
      bus_action_type bus_action;
      logic [7:0]     tx_byte;
      logic           reload_timeout;
      report_type     report_kind;
      logic [1:0]     report_motor;
      logic [7:0]     first_byte;
      logic [7:0]     second_byte;
      logic [7:0]     error_count;
   } rsp_item_type;

endpackage

// File: design/mbps_if.sv
// valid/ready channel interfaces for bus events and bus actions

interface mbps_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] bus_status;
   logic [7:0] rx_byte;
   logic [7:0] command_0;
   logic [7:0] command_1;
   logic [7:0] command_2;
   logic [7:0] command_3;

   modport source (output valid, op, bus_status, rx_byte,
                   command_0, command_1, command_2, command_3,
                   input ready);
   modport sink (input valid, op, bus_status, rx_byte,
                 command_0, command_1, command_2, command_3,
                 output ready);
endinterface

interface mbps_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] bus_action;
   logic [7:0] tx_byte;
   logic       reload_timeout;
   logic [1:0] report_kind;
   logic [1:0] report_motor;
   logic [7:0] first_byte;
   logic [7:0] second_byte;
   logic [7:0] error_count;

   modport source (output valid, bus_action, tx_byte, reload_timeout, report_kind,
                   report_motor, first_byte, second_byte, error_count,
                   input ready);
   modport sink (input valid, bus_action, tx_byte, reload_timeout, report_kind,
                 report_motor, first_byte, second_byte, error_count,
                 output ready);
endinterface

// File: design/mbps_in_stage.sv
// input register for incoming bus event items
module mbps_in_stage import mbps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   mbps_req_if.sink     req_ch,
   input  logic         core_ready,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   assign req_ch.ready = !valid_ff || core_ready;
   assign take = req_ch.valid && req_ch.ready;
   assign valid_in = take || (valid_ff && !core_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{op: req_ch.op, bus_status: req_ch.bus_status,
                      rx_byte: req_ch.rx_byte, command_0: req_ch.command_0,
                      command_1: req_ch.command_1, command_2: req_ch.command_2,
                      command_3: req_ch.command_3};
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

// File: design/mbps_core.sv
// poll sequencer state, next-action logic and result register
module mbps_core import mbps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [7:0]   csr_write_data,
   input  logic         item_valid,
   input  req_item_type item,
   output logic         core_ready,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         rsp_ready
);

   logic [7:0]   base_ff;
   phase_type    phase_ff, phase_in;
   logic [2:0]   write_slot_ff, write_slot_in;
   logic [1:0]   read_slot_ff, read_slot_in;
   logic [7:0]   held_ff, held_in;
   logic [7:0]   counts_ff [MOTOR_COUNT];
   logic [7:0]   counts_in [MOTOR_COUNT];
   logic         rsp_valid_ff;
   rsp_item_type rsp_ff, rsp_in;
   logic         load;

   logic [2:0]             slot_next;
   logic                   slot_wrap;
   logic [1:0]             cmd_sel;
   logic [7:0]             cmd_byte;
   logic [2:0]             wr_idx;
   logic                   count_hit;
   logic [MOTOR_IDX_W-1:0] count_idx;
   logic [7:0]             count_cur;
   logic [7:0]             count_new;
   logic [2:0]             rs_plus;
   logic [1:0]             read_slot_wrap;

   assign core_ready = !rsp_valid_ff || rsp_ready;
   assign load = item_valid && core_ready;

   assign slot_next = write_slot_ff + 3'd1;
   assign slot_wrap = (slot_next == WRITER_END);
   // command index wraps, so slot zero selects the last command
   assign cmd_sel = write_slot_ff[1:0] + 2'd3;
   assign wr_idx = write_slot_ff - 3'd1;
   assign count_hit = ({1'b0, wr_idx} < MOTOR_LIMIT);
   assign count_idx = wr_idx[MOTOR_IDX_W-1:0];
   assign count_cur = count_hit ? counts_ff[count_idx] : 8'd0;
   assign count_new = (item.bus_status == ST_DATA_NACK && count_cur != COUNT_MAX)
                      ? count_cur + 8'd1 : count_cur;
   assign rs_plus = {1'b0, read_slot_ff} + 3'd1;
   assign read_slot_wrap = ({1'b0, rs_plus} >= MOTOR_LIMIT || rs_plus > {1'b0, LAST_READ_SLOT})
                           ? 2'd0 : rs_plus[1:0];

   always_comb begin
      case (cmd_sel)
         2'd0: cmd_byte = item.command_0;
         2'd1: cmd_byte = item.command_1;
         2'd2: cmd_byte = item.command_2;
         default: cmd_byte = item.command_3;
      endcase
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      write_slot_in = write_slot_ff;
      read_slot_in = read_slot_ff;
      held_in = held_ff;
      counts_in = counts_ff;
      if (load) begin
         if (item.op == OP_RESTART) begin
            phase_in = PH_IDLE;
            write_slot_in = 3'd0;
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  if (slot_wrap) begin
                     write_slot_in = 3'd0;
                     phase_in = PH_READ_ADDR;
                  end else begin
                     write_slot_in = slot_next;
                     phase_in = PH_COMMAND;
                  end
               end
               PH_COMMAND: phase_in = PH_DATA_DONE;
               PH_DATA_DONE: begin
                  if (count_hit) begin
                     counts_in[count_idx] = count_new;
                  end
                  phase_in = PH_IDLE;
               end
               PH_READ_ADDR: begin
                  if (item.bus_status != ST_READ_ACK) begin
                     read_slot_in = read_slot_wrap;
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_RX_FIRST;
                  end
               end
               PH_RX_FIRST: begin
                  held_in = item.rx_byte;
                  phase_in = PH_RX_SECOND;
               end
               PH_RX_SECOND: begin
                  read_slot_in = read_slot_wrap;
                  phase_in = PH_IDLE;
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // result for the item in the input register
   always_comb begin
      rsp_in = '{bus_action: ACT_STOP, tx_byte: 8'd0, reload_timeout: 1'b0,
                 report_kind: RPT_NONE, report_motor: 2'd0, first_byte: 8'd0,
                 second_byte: 8'd0, error_count: 8'd0};
      if (item.op == OP_RESTART) begin
         rsp_in.bus_action = ACT_RESTART;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               rsp_in.bus_action = ACT_SEND;
               rsp_in.tx_byte = slot_wrap ? base_ff + 8'd1
                                          : base_ff + {4'd0, slot_next, 1'b0};
            end
            PH_COMMAND: begin
               rsp_in.bus_action = ACT_SEND;
               rsp_in.tx_byte = cmd_byte;
            end
            PH_DATA_DONE: begin
               rsp_in.bus_action = ACT_RESTART;
               rsp_in.reload_timeout = 1'b1;
               rsp_in.error_count = count_hit ? count_new : 8'd0;
            end
            PH_READ_ADDR: begin
               rsp_in.report_motor = read_slot_ff;
               if (item.bus_status != ST_READ_ACK) begin
                  rsp_in.report_kind = RPT_ABSENT;
                  rsp_in.bus_action = ACT_STOP;
               end else begin
                  rsp_in.report_kind = RPT_PRESENT;
                  rsp_in.bus_action = ACT_RX_ACK;
               end
            end
            PH_RX_FIRST: rsp_in.bus_action = ACT_RX_NACK;
            PH_RX_SECOND: begin
               rsp_in.report_kind = RPT_READ_DONE;
               rsp_in.report_motor = read_slot_ff;
               rsp_in.first_byte = held_ff;
               rsp_in.second_byte = item.rx_byte;
               rsp_in.bus_action = ACT_STOP;
            end
            default: rsp_in.bus_action = ACT_STOP;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= ADDRESS_BASE_RESET;
         phase_ff <= PH_IDLE;
         write_slot_ff <= 3'd0;
         read_slot_ff <= 2'd0;
         held_ff <= 8'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            counts_ff[i] <= 8'd0;
         end
      end else begin
         if (csr_write_enable) begin
            base_ff <= csr_write_data;
         end
         phase_ff <= phase_in;
         write_slot_ff <= write_slot_in;
         read_slot_ff <= read_slot_in;
         held_ff <= held_in;
         counts_ff <= counts_in;
         if (core_ready) begin
            rsp_valid_ff <= item_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

`ifndef SYNTH
   // watchdog reload only comes with the stop-restart after a data byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.reload_timeout |-> rsp_ff.bus_action == ACT_RESTART)
      else $error("reload without restart action");

   // a completed read always closes the bus
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.report_kind == RPT_READ_DONE |-> rsp_ff.bus_action == ACT_STOP)
      else $error("read report without stop");

   // error count is only reported alongside the reload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.error_count != 8'd0 |-> rsp_ff.reload_timeout)
      else $error("error count outside write completion");

   // second receive phase is entered only from the first one
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && phase_ff == PH_RX_SECOND |->
         $past(phase_ff) == PH_RX_FIRST || $past(phase_ff) == PH_RX_SECOND)
      else $error("bad entry into second receive phase");
`endif

endmodule

// File: design/motor_bus_poll_sequencer.sv
// Motor bus poll sequencer top level
//
// req_ch carries bus events: op 0 is a completed bus step with its status and
// received byte plus the four current drive commands, op 1 a timeout restart.
// rsp_ch returns one item per event: the next bus action, the byte to send,
// the watchdog reload flag, a presence or read report and the motor's NACK
// count after a written data byte.
// csr_write_enable / csr_write_data load the bus address base (reset 82);
// write it only while no items are in flight.
// Path: an item accepted on req_ch goes into the input register, then the result
// register, which offers it on rsp_ch. One item per cycle is sustained while
// rsp_ch does not stall; the decode between them is a single small state step.
// Reset clears the phase, both slots, the held byte and the NACK counts and
// empties both registers. A stall on rsp_ch holds the result register; the
// input register still takes one more item, after which req_ch.ready drops.
module motor_bus_poll_sequencer import mbps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mbps_req_if.sink   req_ch,
   mbps_rsp_if.source rsp_ch,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic         core_ready;
   logic         item_valid;
   req_item_type item;
   rsp_item_type rsp_item;

   mbps_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .core_ready (core_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   mbps_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (item_valid),
      .item             (item),
      .core_ready       (core_ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_item         (rsp_item),
      .rsp_ready        (rsp_ch.ready)
   );

   assign rsp_ch.bus_action = rsp_item.bus_action;
   assign rsp_ch.tx_byte = rsp_item.tx_byte;
   assign rsp_ch.reload_timeout = rsp_item.reload_timeout;
   assign rsp_ch.report_kind = rsp_item.report_kind;
   assign rsp_ch.report_motor = rsp_item.report_motor;
   assign rsp_ch.first_byte = rsp_item.first_byte;
   assign rsp_ch.second_byte = rsp_item.second_byte;
   assign rsp_ch.error_count = rsp_item.error_count;

endmodule
